### rtl/b32e_pkg.sv
// Shared types, constants and the symbol table of the base32 symbol encoder.
`timescale 1ns / 1ps
`default_nettype none

package b32e_pkg;

    // Max symbols per stream after reset
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd6;

    // Bit reservoir and stream progress carried from one byte to the next
    typedef struct packed {
        logic [3:0] leftover_bits;
        logic [2:0] leftover_count;
        logic [7:0] symbols_emitted;
        logic       limit_reached;
    } enc_state_t;

    // One output word: symbol and end-of-stream mark
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } sym_t;

    // Map a 5-bit group to its ASCII symbol; index 31 has none and gives 0
    function automatic logic [7:0] symbol_of(input logic [4:0] index);
        logic [7:0] code;
        unique case (index)
            5'd0:    code = 8'h32;
            5'd1:    code = 8'h33;
            5'd2:    code = 8'h34;
            5'd3:    code = 8'h35;
            5'd4:    code = 8'h36;
            5'd5:    code = 8'h37;
            5'd6:    code = 8'h38;
            5'd7:    code = 8'h39;
            5'd8:    code = 8'h41;
            5'd9:    code = 8'h42;
            5'd10:   code = 8'h43;
            5'd11:   code = 8'h44;
            5'd12:   code = 8'h45;
            5'd13:   code = 8'h46;
            5'd14:   code = 8'h47;
            5'd15:   code = 8'h48;
            5'd16:   code = 8'h4A;
            5'd17:   code = 8'h4B;
            5'd18:   code = 8'h4D;
            5'd19:   code = 8'h4E;
            5'd20:   code = 8'h50;
            5'd21:   code = 8'h51;
            5'd22:   code = 8'h52;
            5'd23:   code = 8'h53;
            5'd24:   code = 8'h54;
            5'd25:   code = 8'h55;
            5'd26:   code = 8'h56;
            5'd27:   code = 8'h57;
            5'd28:   code = 8'h58;
            5'd29:   code = 8'h59;
            5'd30:   code = 8'h5A;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/b32e_step.sv
// Combinational encode step: one byte in, up to three symbols and the next reservoir out.
`timescale 1ns / 1ps
`default_nettype none

module b32e_step (
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       end_of_data,
    input  wire logic [7:0]                 max_length,
    input  wire b32e_pkg::enc_state_t       state_cur,
    output b32e_pkg::enc_state_t            state_next,
    output logic [1:0]                      sym_count,
    output b32e_pkg::sym_t [2:0]            syms
);

    logic [2:0]  count_clamped;
    logic [11:0] reservoir;
    logic [11:0] aligned;
    logic [3:0]  total_bits;
    logic        two_groups;
    logic [3:0]  rem_wide;
    logic [2:0]  rem_bits;
    logic [4:0]  group0;
    logic [4:0]  group1;
    logic [4:0]  flush_group;
    logic [8:0]  emit1;
    logic [8:0]  emit2;
    logic [8:0]  emit_total;
    logic        hit1;
    logic        hit2;
    logic        limit_now;
    logic [4:0]  keep_mask;

    // Left-align the valid reservoir bits at the top of a 12-bit word
    always_comb
    begin
        count_clamped = (state_cur.leftover_count > 3'd4) ? 3'd4 : state_cur.leftover_count;
        reservoir     = {state_cur.leftover_bits, data_byte};
        aligned       = reservoir << (3'd4 - count_clamped);
        total_bits    = {1'b0, count_clamped} + 4'd8;
        two_groups    = (total_bits >= 4'd10);
        rem_wide      = two_groups ? (total_bits - 4'd10) : (total_bits - 4'd5);
        rem_bits      = rem_wide[2:0];
        group0        = aligned[11:7];
        group1        = aligned[6:2];
        flush_group   = two_groups ? {aligned[1:0], 3'b000} : aligned[6:2];
        emit1         = {1'b0, state_cur.symbols_emitted} + 9'd1;
        emit2         = {1'b0, state_cur.symbols_emitted} + 9'd2;
        hit1          = (emit1 >= {1'b0, max_length});
        hit2          = (emit2 >= {1'b0, max_length});
        keep_mask     = (5'd1 << rem_bits) - 5'd1;
    end

    // Emit groups in order, stop at the limit, flush on end, update reservoir
    always_comb
    begin
        state_next = state_cur;
        sym_count  = 2'd0;
        syms       = '0;
        limit_now  = 1'b0;
        emit_total = '0;
        if (state_cur.limit_reached)
        begin
            // Swallow bytes until the end marker
            if (end_of_data)
            begin
                state_next = '0;
            end
        end
        else
        begin
            syms[0].code = b32e_pkg::symbol_of(group0);
            sym_count    = 2'd1;
            if (hit1)
            begin
                syms[0].last = 1'b1;
                limit_now    = 1'b1;
            end
            else if (two_groups)
            begin
                syms[1].code = b32e_pkg::symbol_of(group1);
                sym_count    = 2'd2;
                if (hit2)
                begin
                    syms[1].last = 1'b1;
                    limit_now    = 1'b1;
                end
            end

            // Flush the zero-padded remainder on the end marker
            if (!limit_now && end_of_data && (rem_bits != 3'd0))
            begin
                if (two_groups)
                begin
                    syms[2].code = b32e_pkg::symbol_of(flush_group);
                    sym_count    = 2'd3;
                end
                else
                begin
                    syms[1].code = b32e_pkg::symbol_of(flush_group);
                    sym_count    = 2'd2;
                end
            end

            emit_total = {1'b0, state_cur.symbols_emitted} + {7'd0, sym_count};

            if (end_of_data)
            begin
                // Mark the final word of the stream and clear
                unique case (sym_count)
                    2'd1:    syms[0].last = 1'b1;
                    2'd2:    syms[1].last = 1'b1;
                    2'd3:    syms[2].last = 1'b1;
                    default: syms[0].last = syms[0].last;
                endcase
                state_next = '0;
            end
            else
            begin
                state_next.symbols_emitted = emit_total[8] ? 8'hFF : emit_total[7:0];
                state_next.limit_reached   = limit_now;
                if (limit_now)
                begin
                    state_next.leftover_count = 3'd0;
                    state_next.leftover_bits  = 4'd0;
                end
                else
                begin
                    state_next.leftover_count = rem_bits;
                    state_next.leftover_bits  = reservoir[3:0] & keep_mask[3:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/b32e_queue.sv
// Four-word shifting result queue; takes up to three words at once, drains one per cycle on pop.
`timescale 1ns / 1ps
`default_nettype none

module b32e_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [1:0]                 push_count,
    input  wire b32e_pkg::sym_t [2:0]       push_syms,
    input  wire logic                       pop,
    output b32e_pkg::sym_t                  head,
    output logic                            not_empty,
    output logic                            room
);

    localparam int DEPTH = 4;

    b32e_pkg::sym_t [DEPTH-1:0] entries_reg;
    b32e_pkg::sym_t [DEPTH-1:0] entries_next;
    logic [2:0]                 count_reg;
    logic [2:0]                 count_next;
    logic [2:0]                 base_count;
    logic [2:0]                 offset [DEPTH];

    assign head      = entries_reg[0];
    assign not_empty = (count_reg != 3'd0);
    assign room      = (count_reg <= 3'd1);

    // Shift on pop, then drop new words in behind the survivors
    always_comb
    begin
        base_count   = count_reg - {2'b00, pop};
        entries_next = pop ? (entries_reg >> $bits(b32e_pkg::sym_t)) : entries_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            offset[i] = 3'(i) - base_count;
            if (push && (3'(i) >= base_count) && (offset[i] < {1'b0, push_count}))
            begin
                entries_next[i] = push_syms[offset[i][1:0]];
            end
        end
        count_next = base_count + (push ? {1'b0, push_count} : 3'd0);
    end

    // Hold word payload
    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

    // Advance fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/base32_symbol_encoder.sv
// Top level of the base32 symbol encoder: input register, encode step, result queue.
// A byte in the input register is encoded and pushed into the queue once the queue has room.
// Throughput: one byte per cycle while the queue holds at most one symbol; output drains
//   one symbol per cycle while out_ready is high.
// Reset (rst_n low, asynchronous) empties the input register and queue, clears the
//   reservoir and sets max_length to 6.
`timescale 1ns / 1ps
`default_nettype none

module base32_symbol_encoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      symbol_code,
    output logic            last_symbol
);

    logic                    s1_valid_reg;
    logic [7:0]              s1_byte_reg;
    logic                    s1_end_reg;
    logic [7:0]              max_length_reg;
    b32e_pkg::enc_state_t    state_reg;
    b32e_pkg::enc_state_t    state_next;
    logic [1:0]              sym_count;
    b32e_pkg::sym_t [2:0]    syms;
    b32e_pkg::sym_t          head;
    logic                    q_room;
    logic                    s1_advance;
    logic                    in_accept;

    assign s1_advance = s1_valid_reg && q_room;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    // Capture max_length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= b32e_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_length_reg <= cfg_wr_data;
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= end_of_data;
        end
    end

    // Reservoir and symbol count, updated as each word enters the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    b32e_step u_step (
        .data_byte   (s1_byte_reg),
        .end_of_data (s1_end_reg),
        .max_length  (max_length_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .sym_count   (sym_count),
        .syms        (syms)
    );

    b32e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_advance),
        .push_count (sym_count),
        .push_syms  (syms),
        .pop        (out_valid && out_ready),
        .head       (head),
        .not_empty  (out_valid),
        .room       (q_room)
    );

    assign symbol_code = head.code;
    assign last_symbol = head.last;

endmodule

`default_nettype wire

### rtl/b32e_checker.sv
// Port-level assertions for the base32 symbol encoder and their binding.
`timescale 1ns / 1ps
`default_nettype none

module b32e_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] symbol_code,
    input wire logic       last_symbol
);

    // A stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(symbol_code)
                                       && $stable(last_symbol)))
        else $error("output word changed while stalled");

    // Every symbol is from the alphabet, or zero for the missing index
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((symbol_code == 8'h00)
                       || (symbol_code >= 8'h32 && symbol_code <= 8'h39)
                       || (symbol_code >= 8'h41 && symbol_code <= 8'h48)
                       || (symbol_code == 8'h4A) || (symbol_code == 8'h4B)
                       || (symbol_code == 8'h4D) || (symbol_code == 8'h4E)
                       || (symbol_code >= 8'h50 && symbol_code <= 8'h5A)))
        else $error("symbol outside the alphabet");

    // With no result pending, the input side must be open
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with an empty result queue");

    // An input word is never held off while the output stays drained
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && $past(!out_valid) && $past(rst_n)) |-> in_ready)
        else $error("input stalled while output idle");

endmodule

bind base32_symbol_encoder b32e_checker u_b32e_checker (.*);

`default_nettype wire

### verif/base32_symbol_encoder_tb.sv
// Self-checking testbench of the base32 symbol encoder: directed table, random streams, scoreboard.
`timescale 1ns / 1ps
module base32_symbol_encoder_tb;

    localparam int LATENCY_PAD    = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AFTER     = 60;
    localparam int PHASE_WORDS    = 20;
    localparam int NO_TYPED       = -1;
    localparam logic [4:0] NO_SYMBOL_INDEX = 5'h1F;
    // Symbol table, first character in the top byte
    localparam logic [30:0][7:0] ALPHABET = "23456789ABCDEFGHJKMNPQRSTUVWXYZ";
    localparam b32e_pkg::sym_t NO_SYM = '0;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

    // One directed step: a byte to send or a max_length to write
    typedef struct packed {
        row_kind_e            kind;
        logic [7:0]           value;
        logic                 eod;
        int                   n_typed;
        b32e_pkg::sym_t [0:2] typed;
    } stim_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte   = 8'd0;
    logic       end_of_data = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] symbol_code;
    logic       last_symbol;

    // Typed expectations travel with the word on offer
    int                   offer_n_typed = NO_TYPED;
    b32e_pkg::sym_t [0:2] offer_typed   = '0;

    // Encoder state as predicted
    logic [7:0]     max_len_model;
    logic [3:0]     res_bits;
    logic [2:0]     res_count;
    logic [7:0]     stream_syms;
    logic           stream_capped;
    b32e_pkg::sym_t pending_symbols [$];

    int errors       = 0;
    int words_in     = 0;
    int symbols_out  = 0;
    int streams_done = 0;
    int settings     = 0;
    int burst_left   = 0;
    int idle_cycles  = 0;

    base32_symbol_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol_code (symbol_code),
        .last_symbol (last_symbol)
    );

    always #1 clk = ~clk;

    initial
    begin : reset_gen
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [7:0] code_of(input logic [4:0] idx);
        return (idx == NO_SYMBOL_INDEX) ? 8'h00 : ALPHABET[30 - idx];
    endfunction

    function automatic void clear_stream();
        res_bits      = '0;
        res_count     = '0;
        stream_syms   = '0;
        stream_capped = 1'b0;
    endfunction

    // Add one symbol at the tail of the expected queue
    function automatic void append_expected(input b32e_pkg::sym_t sym);
        pending_symbols.insert(pending_symbols.size(), sym);
    endfunction

    // Append the symbols that one byte produces to the expected queue
    function automatic void encode_byte(input logic [7:0] data, input logic eod);
        logic [11:0] pool;
        int unsigned bits;
        int unsigned made;
        // Swallow everything up to the end marker once capped
        if (stream_capped)
        begin
            if (eod)
                clear_stream();
            return;
        end
        pool = {res_bits, data};
        bits = res_count + 8;
        made = 0;
        // Emit whole 5-bit groups, stop at the symbol that hits the limit
        while (bits >= 5)
        begin
            append_expected('{code_of(5'(pool >> (bits - 5))), 1'b0});
            made++;
            bits -= 5;
            if (stream_syms != 8'hFF)
                stream_syms++;
            if (stream_syms >= max_len_model)
            begin
                stream_capped = 1'b1;
                break;
            end
        end
        // Flush leftover bits, zero-padded on the right
        if (!stream_capped && eod && bits > 0)
        begin
            append_expected('{code_of(5'(pool << (5 - bits))), 1'b0});
            made++;
        end
        if ((stream_capped || eod) && made > 0)
            pending_symbols[pending_symbols.size() - 1].last = 1'b1;
        if (eod)
            clear_stream();
        else if (!stream_capped)
        begin
            res_count = 3'(bits);
            res_bits  = 4'(pool & ((12'd1 << bits) - 12'd1));
        end
        else
        begin
            res_count = '0;
            res_bits  = '0;
        end
    endfunction

    // Check returned symbols, predict from accepted words, track config writes
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        int base;
        b32e_pkg::sym_t want;
        if (!rst_n)
        begin
            max_len_model = b32e_pkg::MAX_LENGTH_RESET;
            clear_stream();
            pending_symbols.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                symbols_out++;
                if (pending_symbols.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected symbol: expected none, actual code %02h last %0b",
                             $time, symbol_code, last_symbol);
                end
                else
                begin
                    want = pending_symbols.pop_front();
                    if (symbol_code !== want.code)
                    begin
                        errors++;
                        $display("%0t: symbol_code mismatch: expected %02h, actual %02h",
                                 $time, want.code, symbol_code);
                    end
                    if (last_symbol !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_symbol mismatch: expected %0b, actual %0b",
                                 $time, want.last, last_symbol);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                base = pending_symbols.size();
                encode_byte(data_byte, end_of_data);
                // Replace the prediction with the hand-typed result where one is given
                if (offer_n_typed != NO_TYPED)
                begin
                    while (pending_symbols.size() > base)
                        void'(pending_symbols.pop_back());
                    for (int i = 0; i < offer_n_typed; i++)
                        append_expected(offer_typed[i]);
                end
                words_in++;
                if (end_of_data)
                    streams_done++;
            end
            if (cfg_wr_en)
                max_len_model = cfg_wr_data;
        end
    end

    // End the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("base32_symbol_encoder test failed");
            $finish;
        end
    end

    // Receiver: switch between random stall patterns, hold off once for a long stretch
    initial
    begin : receiver
        int cyc;
        int mode;
        bit held;
        cyc  = 0;
        mode = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && words_in >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (cyc % 40 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one word, opening a new burst after a random gap when the last one ran out
    task automatic offer(input logic [7:0] data, input logic eod, input int n_typed,
                         input b32e_pkg::sym_t [0:2] typed);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid      <= 1'b1;
        data_byte     <= data;
        end_of_data   <= eod;
        offer_n_typed <= n_typed;
        offer_typed   <= typed;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid, wait for every expected symbol, then let swallowed words drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_max_length(input logic [7:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    initial
    begin : stimulus
        stim_row_t rows [$];
        logic [7:0] phase_max [$];
        int sent;
        int len;
        rows = '{
            // After reset, max_length 6: all-zero, all-one and one mixed single-byte stream
            '{ROW_WORD, 8'h00, 1'b1, 2, {{8'h32, 1'b0}, {8'h32, 1'b1}, NO_SYM}},
            '{ROW_WORD, 8'hFF, 1'b1, 2, {{8'h00, 1'b0}, {8'h58, 1'b1}, NO_SYM}},
            '{ROW_WORD, 8'h1F, 1'b1, NO_TYPED, '0},
            // Limit reached on the end marker: no flush symbol
            '{ROW_WORD, 8'hA5, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h5A, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'hC3, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h3C, 1'b1, NO_TYPED, '0},
            // Limit reached mid-stream: the rest is swallowed
            '{ROW_WORD, 8'h11, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h22, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h33, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h44, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h55, 1'b0, 0, '0},
            '{ROW_WORD, 8'h66, 1'b1, 0, '0},
            // Smallest limit: the first symbol ends the stream
            '{ROW_CFG,  8'd1,  1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h80, 1'b1, 1, {{8'h4A, 1'b1}, NO_SYM, NO_SYM}},
            '{ROW_WORD, 8'h07, 1'b0, 1, {{8'h32, 1'b1}, NO_SYM, NO_SYM}},
            '{ROW_WORD, 8'h00, 1'b1, 0, '0},
            // Largest limit: forty bits end with no leftover
            '{ROW_CFG,  8'd255, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'hFF, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h00, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'hAA, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'h55, 1'b0, NO_TYPED, '0},
            '{ROW_WORD, 8'hF0, 1'b1, NO_TYPED, '0},
            '{ROW_CFG,  8'd6,  1'b0, NO_TYPED, '0}
        };
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Walk the directed table
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_max_length(rows[i].value);
            else
                offer(rows[i].value, rows[i].eod, rows[i].n_typed, rows[i].typed);
        end

        // Random streams, one max_length setting per phase
        phase_max = '{8'd1, 8'd2, 8'd255, 8'($urandom_range(3, 254)), 8'd13,
                      b32e_pkg::MAX_LENGTH_RESET};
        foreach (phase_max[p])
        begin
            write_max_length(phase_max[p]);
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    offer(random_byte(), k == len - 1, NO_TYPED, '0);
                sent += len;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d streams and checked %0d symbols",
                 words_in, streams_done, symbols_out);
        $display("Swept %0d max_length settings from 1 to 255 under random stalls", settings);
        if (errors == 0 && pending_symbols.size() == 0)
            $display("base32_symbol_encoder test passed");
        else
            $display("base32_symbol_encoder test failed");
        $finish;
    end

endmodule

### sim.f
rtl/b32e_pkg.sv
rtl/b32e_step.sv
rtl/b32e_queue.sv
rtl/base32_symbol_encoder.sv
rtl/b32e_checker.sv
verif/base32_symbol_encoder_tb.sv
